// ----- design/dpba_pkg.sv -----
// Shared types and constants of the dual-pool bitmap allocator.
// Used by the top level, the word unit, the sequencer and the testbench; depends on nothing.
package dpba_pkg;

  localparam int IDX_W = 13;
  localparam int CNT_W = 14;
  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd76;

  localparam int BLOCK_COUNT_DEF   = 8192;
  localparam int INODE_COUNT_DEF   = 1024;
  localparam int MAP_WORD_BITS_DEF = 32;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    POOL_DATA  = 1'b0,
    POOL_INODE = 1'b1
  } pool_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_FINISH
  } state_t;

  typedef enum logic {
    OP_FIND_SET,
    OP_CLEAR_BIT
  } unit_op_t;

  typedef struct packed {
    logic found;
    logic bit_set;
  } unit_flags_t;

  typedef struct packed {
    cmd_t             command;
    pool_t            pool;
    logic [IDX_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] free_count;
  } rsp_t;

  typedef logic [CFG_W-1:0] cfg_word_t;

endpackage

// ----- design/dpba_chan_if.sv -----
// Valid/ready channel carrying one payload of a chosen type.
// Payload types come from dpba_pkg.
interface dpba_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/dual_pool_bitmap_allocator.sv -----
// Dual-pool first-fit bitmap allocator, top level.
// Uses dpba_pkg, dpba_chan_if, dpba_ram, dpba_word_unit and dpba_ctrl.
//
// Channels: req (command, pool, entry_index) in, rsp (status, granted_index,
// free_count) out, and cfg carrying first_data_block; each moves a request
// when valid and ready are both high. cfg is always ready.
// Both bitmaps sit in one word memory, data pool words first, inode pool words
// after them; MAP_WORD_BITS is a power of two.
// Reset: a clearing pass writes zero to every map word, one word a cycle,
// BLOCK_COUNT/MAP_WORD_BITS + INODE_COUNT/MAP_WORD_BITS words (288 at the
// defaults); req.ready stays low until it ends. first_data_block resets to 76.
// A rejected request goes straight to the finish state; a free first reads the word
// holding the entry, then checks and clears its bit. An allocate reads the map words
// from the first word of the pool's range to the word holding the lowest clear bit
// (at most 256 at the defaults); the shared word unit checks one word per cycle.
// req.ready returns the cycle after the result loads.
// One request is in work at a time. A new request is taken while its result
// waits; if rsp stalls, the next result holds in the sequencer until the
// register frees.
module dual_pool_bitmap_allocator #(
  parameter int BLOCK_COUNT   = dpba_pkg::BLOCK_COUNT_DEF,
  parameter int INODE_COUNT   = dpba_pkg::INODE_COUNT_DEF,
  parameter int MAP_WORD_BITS = dpba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  dpba_chan_if.sink    req,
  dpba_chan_if.source  rsp,
  dpba_chan_if.sink    cfg
);

  localparam int SH          = $clog2(MAP_WORD_BITS);
  localparam int BLOCK_WORDS = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int INODE_WORDS = (INODE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int TOTAL_WORDS = BLOCK_WORDS + INODE_WORDS;
  localparam int AW          = $clog2(TOTAL_WORDS);
  localparam int MAXC        = (BLOCK_COUNT > INODE_COUNT) ? BLOCK_COUNT : INODE_COUNT;
  localparam int IW          = $clog2(MAXC + 1);
  localparam int CfgW        = dpba_pkg::CFG_W;
  localparam int CmpW        = (IW > CfgW) ? IW : CfgW;

  logic [CfgW-1:0]          first_data_block;
  logic [IW-1:0]            lo_data;
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [MAP_WORD_BITS-1:0] wr_data, rd_data, unit_word;
  dpba_pkg::unit_op_t       unit_op;
  logic [SH-1:0]            unit_lo_bit, unit_hi_bit, unit_sel_bit, unit_pos;
  dpba_pkg::unit_flags_t    unit_flags;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_data_block <= dpba_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      first_data_block <= cfg.data;
    end
  end

  // Clamp the data pool's low bound to the pool size.
  assign lo_data = (CmpW'(first_data_block) >= CmpW'(BLOCK_COUNT)) ? IW'(BLOCK_COUNT)
                                                                  : IW'(first_data_block);

  dpba_ram #(
    .DEPTH (TOTAL_WORDS),
    .WIDTH (MAP_WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dpba_word_unit #(
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_unit (
    .op        (unit_op),
    .word      (rd_data),
    .lo_bit    (unit_lo_bit),
    .hi_bit    (unit_hi_bit),
    .sel_bit   (unit_sel_bit),
    .first_pos (unit_pos),
    .word_out  (unit_word),
    .flags     (unit_flags)
  );

  dpba_ctrl #(
    .BLOCK_COUNT   (BLOCK_COUNT),
    .INODE_COUNT   (INODE_COUNT),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .lo_data      (lo_data),
    .req          (req),
    .rsp          (rsp),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .unit_op      (unit_op),
    .unit_lo_bit  (unit_lo_bit),
    .unit_hi_bit  (unit_hi_bit),
    .unit_sel_bit (unit_sel_bit),
    .unit_pos     (unit_pos),
    .unit_word    (unit_word),
    .unit_flags   (unit_flags)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while a request is in work");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req.ready)
    else $error("request port open during the clearing pass");

  a_fail_zero_index: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != dpba_pkg::ST_OK |-> rsp.data.granted_index == '0)
    else $error("failed request returned a nonzero index");

  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status == dpba_pkg::ST_FULL |-> rsp.data.free_count == '0)
    else $error("pool reported full with free entries counted");

endmodule

// ----- design/dpba_ram.sv -----
// Single-port-write, single-port-read bitmap word memory with registered read.
// Depends on nothing outside itself.
module dpba_ram #(
  parameter int DEPTH = 288,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/dpba_word_unit.sv -----
// Shared word unit: lowest clear bit inside a bit window, and set or clear of one bit.
// Uses dpba_pkg for the operation code and the flag struct.
module dpba_word_unit #(
  parameter int MAP_WORD_BITS = dpba_pkg::MAP_WORD_BITS_DEF
) (
  input  dpba_pkg::unit_op_t                op,
  input  logic [MAP_WORD_BITS-1:0]          word,
  input  logic [$clog2(MAP_WORD_BITS)-1:0]  lo_bit,
  input  logic [$clog2(MAP_WORD_BITS)-1:0]  hi_bit,
  input  logic [$clog2(MAP_WORD_BITS)-1:0]  sel_bit,
  output logic [$clog2(MAP_WORD_BITS)-1:0]  first_pos,
  output logic [MAP_WORD_BITS-1:0]          word_out,
  output dpba_pkg::unit_flags_t             flags
);

  localparam int SH = $clog2(MAP_WORD_BITS);

  logic [MAP_WORD_BITS-1:0] avail;
  logic [SH-1:0]            tgt;
  logic [MAP_WORD_BITS-1:0] onehot;

  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      avail[b] = !word[b] && (SH'(b) >= lo_bit) && (SH'(b) <= hi_bit);
    end
    // Scan downward so the lowest free bit wins.
    first_pos = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        first_pos = SH'(b);
      end
    end
    flags.found   = |avail;
    flags.bit_set = word[sel_bit];
    tgt    = (op == dpba_pkg::OP_FIND_SET) ? first_pos : sel_bit;
    onehot = MAP_WORD_BITS'(1) << tgt;
    word_out = (op == dpba_pkg::OP_FIND_SET) ? (word | onehot) : (word & ~onehot);
  end

endmodule

// ----- design/dpba_ctrl.sv -----
// Request sequencer: memory clearing pass, word-by-word first-fit scan, frees,
// in-use counters and the result register. Uses dpba_pkg and dpba_chan_if.
module dpba_ctrl #(
  parameter int BLOCK_COUNT   = dpba_pkg::BLOCK_COUNT_DEF,
  parameter int INODE_COUNT   = dpba_pkg::INODE_COUNT_DEF,
  parameter int MAP_WORD_BITS = dpba_pkg::MAP_WORD_BITS_DEF,
  localparam int SH          = $clog2(MAP_WORD_BITS),
  localparam int BLOCK_WORDS = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
  localparam int INODE_WORDS = (INODE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
  localparam int TOTAL_WORDS = BLOCK_WORDS + INODE_WORDS,
  localparam int AW          = $clog2(TOTAL_WORDS),
  localparam int MAXC        = (BLOCK_COUNT > INODE_COUNT) ? BLOCK_COUNT : INODE_COUNT,
  localparam int IW          = $clog2(MAXC + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [IW-1:0]               lo_data,
  dpba_chan_if.sink                   req,
  dpba_chan_if.source                 rsp,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [MAP_WORD_BITS-1:0]    wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [MAP_WORD_BITS-1:0]    rd_data,
  output dpba_pkg::unit_op_t          unit_op,
  output logic [SH-1:0]               unit_lo_bit,
  output logic [SH-1:0]               unit_hi_bit,
  output logic [SH-1:0]               unit_sel_bit,
  input  logic [SH-1:0]               unit_pos,
  input  logic [MAP_WORD_BITS-1:0]    unit_word,
  input  dpba_pkg::unit_flags_t       unit_flags
);

  localparam int PW   = IW - SH;
  localparam int BUW  = $clog2(BLOCK_COUNT + 1);
  localparam int IUW  = $clog2(INODE_COUNT + 1);
  localparam int IdxW = dpba_pkg::IDX_W;
  localparam int CntW = dpba_pkg::CNT_W;
  localparam int CmpW = (IW > IdxW) ? IW : IdxW;

  dpba_pkg::state_t  state, state_next;
  dpba_pkg::pool_t   pool_q, pool_q_next;
  logic [IW-1:0]     idx_q, idx_q_next;
  logic [IW-1:0]     lo_q, lo_q_next;
  logic [IW-1:0]     hi_m1_q, hi_m1_q_next;
  logic [PW-1:0]     cur_word, cur_word_next;
  dpba_pkg::status_t status_q, status_q_next;
  logic [IW-1:0]     granted_q, granted_q_next;
  logic [BUW-1:0]    blocks_in_use, blocks_in_use_next;
  logic [IUW-1:0]    inodes_in_use, inodes_in_use_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic              rsp_valid, rsp_valid_next;
  dpba_pkg::rsp_t    rsp_data, rsp_data_next;

  logic              req_ready;
  logic [IW-1:0]     lo_sel, hi_sel;
  logic [CmpW-1:0]   idx_w;
  logic [AW-1:0]     req_base, q_base;
  logic              at_first, at_last;
  logic [IW-1:0]     span, used_ext, free_now;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    lo_sel   = (req.data.pool == dpba_pkg::POOL_INODE) ? '0 : lo_data;
    hi_sel   = (req.data.pool == dpba_pkg::POOL_INODE) ? IW'(INODE_COUNT) : IW'(BLOCK_COUNT);
    idx_w    = CmpW'(req.data.entry_index);
    req_base = (req.data.pool == dpba_pkg::POOL_INODE) ? AW'(BLOCK_WORDS) : '0;
    q_base   = (pool_q == dpba_pkg::POOL_INODE) ? AW'(BLOCK_WORDS) : '0;
    at_first = (cur_word == lo_q[IW-1:SH]);
    at_last  = (cur_word == hi_m1_q[IW-1:SH]);
    span     = (pool_q == dpba_pkg::POOL_INODE) ? IW'(INODE_COUNT)
                                                : IW'(BLOCK_COUNT) - lo_data;
    used_ext = (pool_q == dpba_pkg::POOL_INODE) ? IW'(inodes_in_use) : IW'(blocks_in_use);
    free_now = (used_ext >= span) ? '0 : span - used_ext;
  end

  always_comb begin
    state_next         = state;
    pool_q_next        = pool_q;
    idx_q_next         = idx_q;
    lo_q_next          = lo_q;
    hi_m1_q_next       = hi_m1_q;
    cur_word_next      = cur_word;
    status_q_next      = status_q;
    granted_q_next     = granted_q;
    blocks_in_use_next = blocks_in_use;
    inodes_in_use_next = inodes_in_use;
    clr_addr_next      = clr_addr;
    rsp_valid_next     = rsp_valid;
    rsp_data_next      = rsp_data;
    req_ready          = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = '0;
    wr_data            = unit_word;
    rd_en              = 1'b0;
    rd_addr            = '0;
    unit_op            = dpba_pkg::OP_FIND_SET;
    unit_lo_bit        = at_first ? lo_q[SH-1:0] : '0;
    unit_hi_bit        = at_last ? hi_m1_q[SH-1:0] : '1;
    unit_sel_bit       = idx_q[SH-1:0];

    // Drop the result once the receiver takes it.
    if (rsp_valid && rsp.ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      dpba_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(TOTAL_WORDS - 1)) begin
          state_next = dpba_pkg::S_IDLE;
        end
      end

      dpba_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          pool_q_next    = req.data.pool;
          lo_q_next      = lo_sel;
          hi_m1_q_next   = hi_sel - IW'(1);
          idx_q_next     = IW'(req.data.entry_index);
          granted_q_next = '0;
          if (req.data.command == dpba_pkg::CMD_ALLOC) begin
            if (lo_sel >= hi_sel) begin
              status_q_next = dpba_pkg::ST_FULL;
              state_next    = dpba_pkg::S_FINISH;
            end else begin
              cur_word_next = lo_sel[IW-1:SH];
              rd_en         = 1'b1;
              rd_addr       = req_base + AW'(lo_sel[IW-1:SH]);
              state_next    = dpba_pkg::S_SCAN;
            end
          end else if (idx_w < CmpW'(lo_sel) || idx_w >= CmpW'(hi_sel)) begin
            status_q_next = dpba_pkg::ST_RANGE;
            state_next    = dpba_pkg::S_FINISH;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = req_base + AW'(idx_w[IW-1:SH]);
            state_next = dpba_pkg::S_FREE_CHK;
          end
        end
      end

      dpba_pkg::S_SCAN: begin
        unit_op = dpba_pkg::OP_FIND_SET;
        if (unit_flags.found) begin
          wr_en          = 1'b1;
          wr_addr        = q_base + AW'(cur_word);
          status_q_next  = dpba_pkg::ST_OK;
          granted_q_next = {cur_word, unit_pos};
          if (pool_q == dpba_pkg::POOL_INODE) begin
            inodes_in_use_next = inodes_in_use + IUW'(1);
          end else begin
            blocks_in_use_next = blocks_in_use + BUW'(1);
          end
          state_next = dpba_pkg::S_FINISH;
        end else if (at_last) begin
          status_q_next = dpba_pkg::ST_FULL;
          state_next    = dpba_pkg::S_FINISH;
        end else begin
          // Advance to the next word; its data arrives next cycle.
          cur_word_next = cur_word + PW'(1);
          rd_en         = 1'b1;
          rd_addr       = q_base + AW'(cur_word + PW'(1));
        end
      end

      dpba_pkg::S_FREE_CHK: begin
        unit_op = dpba_pkg::OP_CLEAR_BIT;
        if (!unit_flags.bit_set) begin
          status_q_next = dpba_pkg::ST_ALREADY_FREE;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = q_base + AW'(idx_q[IW-1:SH]);
          status_q_next  = dpba_pkg::ST_OK;
          granted_q_next = idx_q;
          if (pool_q == dpba_pkg::POOL_INODE) begin
            if (inodes_in_use != '0) begin
              inodes_in_use_next = inodes_in_use - IUW'(1);
            end
          end else if (blocks_in_use != '0) begin
            blocks_in_use_next = blocks_in_use - BUW'(1);
          end
        end
        state_next = dpba_pkg::S_FINISH;
      end

      dpba_pkg::S_FINISH: begin
        // Hold here until the result register is free.
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next              = 1'b1;
          rsp_data_next.status        = status_q;
          rsp_data_next.granted_index = IdxW'(granted_q);
          rsp_data_next.free_count    = CntW'(free_now);
          state_next                  = dpba_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = dpba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dpba_pkg::S_CLEAR;
      clr_addr      <= '0;
      blocks_in_use <= '0;
      inodes_in_use <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      blocks_in_use <= blocks_in_use_next;
      inodes_in_use <= inodes_in_use_next;
      rsp_valid     <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pool_q    <= pool_q_next;
    idx_q     <= idx_q_next;
    lo_q      <= lo_q_next;
    hi_m1_q   <= hi_m1_q_next;
    cur_word  <= cur_word_next;
    status_q  <= status_q_next;
    granted_q <= granted_q_next;
    rsp_data  <= rsp_data_next;
  end

endmodule

// ----- tb/dual_pool_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dual_pool_bitmap_allocator: predicts every response.
// Depends on dpba_pkg, dpba_chan_if and the allocator top level; needs no files.
module dual_pool_bitmap_allocator_tb;

  localparam int BLOCKS    = dpba_pkg::BLOCK_COUNT_DEF;
  localparam int INODES    = dpba_pkg::INODE_COUNT_DEF;
  localparam int RUN_LIMIT = 1_000_000;

  typedef enum int {RX_OPEN, RX_JITTER, RX_HOLD} rx_mode_t;

  // Mirror of both bitmaps, their use counts and the first data block.
  class pool_tracker;
    bit                  block_used[BLOCKS];
    bit                  inode_used[INODES];
    int unsigned         blocks_held;
    int unsigned         inodes_held;
    dpba_pkg::cfg_word_t first_block;
    int                  live_blocks[$];
    int                  live_inodes[$];
    dpba_pkg::rsp_t      awaited[$];
    int unsigned         fails;

    function new();
      first_block = dpba_pkg::CFG_RESET;
    endfunction

    function void set_first_block(dpba_pkg::cfg_word_t v);
      first_block = v;
    endfunction

    function int unsigned free_left(dpba_pkg::pool_t p);
      int unsigned span;
      int unsigned held;
      span = (p == dpba_pkg::POOL_INODE) ? INODES
           : BLOCKS - ((first_block < BLOCKS) ? first_block : BLOCKS);
      held = (p == dpba_pkg::POOL_INODE) ? inodes_held : blocks_held;
      return (held >= span) ? 0 : span - held;
    endfunction

    function void note_request(dpba_pkg::req_t r);
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    idx;
      bit             taken;
      dpba_pkg::rsp_t e;
      lo = (r.pool == dpba_pkg::POOL_INODE) ? 0
         : ((first_block < BLOCKS) ? first_block : BLOCKS);
      hi = (r.pool == dpba_pkg::POOL_INODE) ? INODES : BLOCKS;
      idx = r.entry_index;
      e.status = dpba_pkg::ST_FULL;
      e.granted_index = '0;
      if (r.command == dpba_pkg::CMD_ALLOC) begin
        for (int unsigned i = lo; i < hi; i++) begin
          taken = (r.pool == dpba_pkg::POOL_INODE) ? inode_used[i] : block_used[i];
          if (!taken) begin
            if (r.pool == dpba_pkg::POOL_INODE) begin
              inode_used[i] = 1'b1;
              inodes_held++;
              live_inodes.push_back(i);
            end else begin
              block_used[i] = 1'b1;
              blocks_held++;
              live_blocks.push_back(i);
            end
            e.status = dpba_pkg::ST_OK;
            e.granted_index = i[dpba_pkg::IDX_W-1:0];
            break;
          end
        end
      end else if (idx < lo || idx >= hi) begin
        e.status = dpba_pkg::ST_RANGE;
      end else if (!((r.pool == dpba_pkg::POOL_INODE) ? inode_used[idx]
                                                      : block_used[idx])) begin
        e.status = dpba_pkg::ST_ALREADY_FREE;
      end else begin
        if (r.pool == dpba_pkg::POOL_INODE) begin
          inode_used[idx] = 1'b0;
          if (inodes_held > 0) inodes_held--;
          foreach (live_inodes[k]) if (live_inodes[k] == idx) begin
            live_inodes.delete(k);
            break;
          end
        end else begin
          block_used[idx] = 1'b0;
          if (blocks_held > 0) blocks_held--;
          foreach (live_blocks[k]) if (live_blocks[k] == idx) begin
            live_blocks.delete(k);
            break;
          end
        end
        e.status = dpba_pkg::ST_OK;
        e.granted_index = r.entry_index;
      end
      e.free_count = dpba_pkg::CNT_W'(free_left(r.pool));
      awaited.push_back(e);
    endfunction

    function void check_result(dpba_pkg::rsp_t got);
      dpba_pkg::rsp_t e;
      if (awaited.size() == 0) begin
        $error("response with no request outstanding: status %0d index %0d count %0d",
               got.status, got.granted_index, got.free_count);
        fails++;
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        fails++;
      end
      if (got.granted_index !== e.granted_index) begin
        $error("granted_index: expected %0d, got %0d", e.granted_index, got.granted_index);
        fails++;
      end
      if (got.free_count !== e.free_count) begin
        $error("free_count: expected %0d, got %0d", e.free_count, got.free_count);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  dpba_chan_if #(.payload_t(dpba_pkg::req_t))      req_if ();
  dpba_chan_if #(.payload_t(dpba_pkg::rsp_t))      rsp_if ();
  dpba_chan_if #(.payload_t(dpba_pkg::cfg_word_t)) cfg_if ();

  dual_pool_bitmap_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source),
    .cfg (cfg_if.sink)
  );

  pool_tracker sb;
  int          burst_left;
  int          rx_left;
  rx_mode_t    rx_mode;
  int unsigned cycle_count;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Receiver stalls in runs: open, jittery or held low.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rx_left <= 0;
      rx_mode <= RX_OPEN;
    end else if (rx_left == 0) begin
      rx_left <= $urandom_range(4, 40);
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rsp_if.ready <= 1'b1;
    end else begin
      rx_left <= rx_left - 1;
      case (rx_mode)
        RX_OPEN:   rsp_if.ready <= 1'b1;
        RX_JITTER: rsp_if.ready <= 1'($urandom_range(0, 1));
        default:   rsp_if.ready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** dual_pool_bitmap_allocator: FAILED **");
    $finish;
  end

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 15);
    return $urandom_range(1, 10);
  endfunction

  task automatic issue(dpba_pkg::cmd_t c, dpba_pkg::pool_t p,
                       logic [dpba_pkg::IDX_W-1:0] idx, int gap);
    dpba_pkg::req_t r;
    r.command = c;
    r.pool = p;
    r.entry_index = idx;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(r);
  endtask

  // Hold off new requests until every response is back.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_first_block(dpba_pkg::cfg_word_t v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_first_block(v);
  endtask

  task automatic issue_random(bit steady);
    int                         roll;
    dpba_pkg::pool_t            p;
    dpba_pkg::cmd_t             c;
    logic [dpba_pkg::IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    p = dpba_pkg::pool_t'($urandom_range(0, 1));
    c = dpba_pkg::CMD_FREE;
    idx = dpba_pkg::IDX_W'($urandom_range(0, BLOCKS - 1));
    if (roll < 45) begin
      c = dpba_pkg::CMD_ALLOC;
    end else if (roll < 80) begin
      // free an entry that is held, else fall back to an allocate
      if (p == dpba_pkg::POOL_INODE && sb.live_inodes.size() != 0)
        idx = dpba_pkg::IDX_W'(
          sb.live_inodes[$urandom_range(0, sb.live_inodes.size() - 1)]);
      else if (p == dpba_pkg::POOL_DATA && sb.live_blocks.size() != 0)
        idx = dpba_pkg::IDX_W'(
          sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)]);
      else
        c = dpba_pkg::CMD_ALLOC;
    end else if (p == dpba_pkg::POOL_INODE && roll < 90) begin
      idx = dpba_pkg::IDX_W'($urandom_range(0, INODES - 1));
    end
    issue(c, p, idx, steady ? 0 : next_gap());
  endtask

  initial begin
    int                  phase_len[6];
    dpba_pkg::cfg_word_t fdb;
    sb = new();
    phase_len = '{220, 30, 100, 250, 150, 200};
    burst_left = 0;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset value of the first data block.
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd0, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd75, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd76, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd8191, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_INODE, 13'd1024, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_INODE, 13'd8191, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_INODE, 13'd1023, next_gap());
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_DATA, 13'd0, next_gap());
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_DATA, 13'd8191, next_gap());
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_INODE, 13'd4096, next_gap());
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_INODE, 13'd0, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd76, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd76, next_gap());
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_DATA, 13'd5555, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_INODE, 13'd0, next_gap());
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_INODE, 13'd0, next_gap());
    // One-entry data pool with blocks held below it: count saturates, then full.
    write_first_block(13'd8191);
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_DATA, 13'd0, next_gap());
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_DATA, 13'd0, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd77, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd8191, next_gap());
    write_first_block(13'd0);
    issue(dpba_pkg::CMD_ALLOC, dpba_pkg::POOL_DATA, 13'd0, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_DATA, 13'd0, next_gap());
    issue(dpba_pkg::CMD_FREE, dpba_pkg::POOL_INODE, 13'd0, next_gap());

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       fdb = 13'd0;
        1:       fdb = 13'd8191;
        2:       fdb = 13'd8100;
        3:       fdb = dpba_pkg::CFG_RESET;
        4:       fdb = dpba_pkg::CFG_W'($urandom_range(0, 8191));
        default: fdb = dpba_pkg::CFG_W'($urandom_range(0, 300));
      endcase
      write_first_block(fdb);
      for (int n = 0; n < phase_len[p]; n++) begin
        if ($urandom_range(0, 99) == 0) drain();
        issue_random(p == 3);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.fails == 0)
      $display("** dual_pool_bitmap_allocator: PASSED **");
    else
      $display("** dual_pool_bitmap_allocator: FAILED **");
    $finish;
  end

endmodule
